// ----- rtl/core/tlf_pkg.sv -----
// ----------------------------------------------------------------------------
// tlf_pkg: shared types and constants for the thermal/load frequency limiter
// field widths, temperature bands, usage thresholds, register and state codes
// ----------------------------------------------------------------------------
`default_nettype none

package tlf_pkg;

    localparam int FREQ_W     = 22;
    localparam int TEMP_W     = 9;
    localparam int USAGE_W    = 14;
    localparam int QUOT_W     = 14;
    localparam int TICK_IN_W  = 32;
    localparam int CORE_N     = 4;
    localparam int CORE_IDX_W = 2;
    localparam int LOW_CNT_W  = 8;
    localparam int DIGIT_W    = 4;
    localparam int DIV_BIT_W  = 4;

    typedef logic [FREQ_W-1:0]        freq_t;
    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [USAGE_W-1:0]       usage_t;
    typedef logic [CORE_N-1:0]        core_mask_t;
    typedef logic [CORE_IDX_W-1:0]    core_idx_t;
    typedef logic [TICK_IN_W-1:0]     tick_cnt_t;
    typedef logic [LOW_CNT_W-1:0]     low_cnt_t;

    // register indexes of the write port
    typedef enum logic [1:0] {
        REG_FULL   = 2'd0,
        REG_LEVEL0 = 2'd1,
        REG_LEVEL1 = 2'd2,
        REG_FLOOR  = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_CHECK,
        S_DIV,
        S_FIN
    } tlf_state_t;

    localparam freq_t RESET_FULL   = 22'd1400000;
    localparam freq_t RESET_LEVEL0 = 22'd1200000;
    localparam freq_t RESET_LEVEL1 = 22'd1000000;
    localparam freq_t RESET_FLOOR  = 22'd800000;

    localparam temp_t T_BAND0       = 9'sd45;
    localparam temp_t T_BAND1       = 9'sd52;
    localparam temp_t T_LEVEL2      = 9'sd62;
    localparam temp_t T_LEVEL2_LOW  = 9'sd57;
    localparam temp_t T_CHARGE_STOP = 9'sd57;
    localparam temp_t T_CHARGE_GO   = 9'sd56;
    localparam temp_t T_DOWN1       = 9'sd57;
    localparam temp_t T_DOWN2       = 9'sd67;
    localparam temp_t T_BOOST_MAX   = 9'sd64;
    localparam temp_t T_BOOST_LIMIT = 9'sd68;

    localparam int U_OVER  = 79;
    localparam int U_UNDER = 48;

    localparam usage_t FULL_SCALE = 14'd10000;
    // whole-percent compares done on the hundredths value
    localparam usage_t USAGE_ABOVE_OVER  = USAGE_W'((U_OVER + 1) * 100);
    localparam usage_t USAGE_ABOVE_UNDER = USAGE_W'((U_UNDER + 1) * 100);
    localparam usage_t USAGE_BELOW_OVER  = USAGE_W'(U_OVER * 100);

    localparam low_cnt_t LOW_CNT_MAX     = '1;
    localparam low_cnt_t LOW_CNT_RESTART = 8'd5;

    localparam core_idx_t CORE_A = 2'd1;
    localparam core_idx_t CORE_B = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/core/tlf_in_if.sv -----
// ----------------------------------------------------------------------------
// tlf_in_if: tick channel
// valid/ready handshake carrying one sampled tick
// ----------------------------------------------------------------------------
`default_nettype none

interface tlf_in_if;
    import tlf_pkg::*;

    logic       valid;
    logic       ready;
    logic       op;
    temp_t      temp_c;
    tick_cnt_t  idle_ticks;
    tick_cnt_t  total_ticks;
    logic       die_error;
    core_mask_t online_mask;
    core_idx_t  current_core;

    modport source (
        output valid, op, temp_c, idle_ticks, total_ticks, die_error,
               online_mask, current_core,
        input  ready
    );

    modport sink (
        input  valid, op, temp_c, idle_ticks, total_ticks, die_error,
               online_mask, current_core,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/tlf_out_if.sv -----
// ----------------------------------------------------------------------------
// tlf_out_if: result channel
// valid/ready handshake carrying the cap, core masks, charge flag and usage
// ----------------------------------------------------------------------------
`default_nettype none

interface tlf_out_if;
    import tlf_pkg::*;

    logic       valid;
    logic       ready;
    freq_t      max_freq_khz;
    core_mask_t stop_mask;
    core_mask_t start_mask;
    logic       charge_stop;
    usage_t     usage_x100;

    modport source (
        output valid, max_freq_khz, stop_mask, start_mask, charge_stop, usage_x100,
        input  ready
    );

    modport sink (
        input  valid, max_freq_khz, stop_mask, start_mask, charge_stop, usage_x100,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/tlf_sdiv.sv -----
// ----------------------------------------------------------------------------
// tlf_sdiv: serial scaled quotient
// floor(num * 10000 / den) for num <= den, one conditional subtract per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tlf_sdiv #(
    parameter int W = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [W-1:0]   num,
    input  wire logic [W-1:0]   den,
    output tlf_pkg::usage_t     quot,
    output logic                done
);
    import tlf_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 phase_b_reg, phase_b_next;
    logic                 done_reg, done_next;
    logic [DIV_BIT_W-1:0] bit_reg, bit_next;
    logic [W-1:0]         rem_reg, rem_next;
    usage_t               q_reg, q_next;
    usage_t               q_shift;
    logic [W+1:0]         dbl_diff;
    logic [W+1:0]         add_sum;
    logic [W+1:0]         add_diff;
    logic                 last_step;

    always_comb
    begin
        dbl_diff  = {1'b0, rem_reg, 1'b0} - {2'b00, den};
        add_sum   = {2'b00, rem_reg} + {2'b00, num};
        add_diff  = add_sum - {2'b00, den};
        q_shift   = {q_reg[QUOT_W-2:0], 1'b0};
        busy_next    = busy_reg;
        phase_b_next = phase_b_reg;
        bit_next     = bit_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        done_next    = 1'b0;
        last_step    = 1'b0;
        if (start)
        begin
            busy_next    = 1'b1;
            phase_b_next = 1'b0;
            bit_next     = DIV_BIT_W'(QUOT_W - 1);
            rem_next     = '0;
            q_next       = '0;
        end
        else if (busy_reg)
        begin
            if (!phase_b_reg)
            begin
                // doubling step: remainder times two against the divisor
                if (!dbl_diff[W+1])
                begin
                    rem_next = dbl_diff[W-1:0];
                    q_next   = q_shift + usage_t'(1);
                end
                else
                begin
                    rem_next = {rem_reg[W-2:0], 1'b0};
                    q_next   = q_shift;
                end
                if (FULL_SCALE[bit_reg])
                begin
                    phase_b_next = 1'b1;
                end
                else
                begin
                    last_step = 1'b1;
                end
            end
            else
            begin
                // scale bit set: add the numerator once more
                if (!add_diff[W+1])
                begin
                    rem_next = add_diff[W-1:0];
                    q_next   = q_reg + usage_t'(1);
                end
                else
                begin
                    rem_next = add_sum[W-1:0];
                end
                phase_b_next = 1'b0;
                last_step    = 1'b1;
            end
            if (last_step)
            begin
                if (bit_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    bit_next = bit_reg - DIV_BIT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            phase_b_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            phase_b_reg <= phase_b_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

    // remainder stays below the divisor through the whole run
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < den))
        else $error("tlf_sdiv: remainder not below divisor");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && busy_reg))
        else $error("tlf_sdiv: start while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("tlf_sdiv: done while still busy");

endmodule

`default_nettype wire

// ----- rtl/core/thermal_load_freq_limiter.sv -----
// ----------------------------------------------------------------------------
// thermal_load_freq_limiter: thermal and load driven cpu frequency cap
// usage from tick deltas, banded cap, warning hold, die latch, core stop/start
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A normal tick walks the idle and total
// counters through a 4-bit digit-serial subtractor, runs the serial scaled
// divider (one conditional subtract per step) when the deltas allow an
// update, then settles the cap, core masks and charge flag in the finish
// state once the output register is free. A tick whose deltas skip the
// update goes from the check state straight to finish. A boost tick skips
// the counters and goes from idle straight to finish. The next tick is taken
// as soon as the block is back in idle, even while the previous result waits
// in the output register. Frequency registers are written through wr_en/
// wr_index/wr_data, by the user only while the block is idle (the block does
// not enforce this); last_cap keeps the floor value from reset.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_load_freq_limiter #(
    parameter int TICK_WIDTH = 32,
    parameter int HOLD_LIMIT = 60
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    tlf_in_if.sink                    tick,
    tlf_out_if.source                 result,
    input  wire logic                 wr_en,
    input  tlf_pkg::reg_index_t       wr_index,
    input  tlf_pkg::freq_t            wr_data
);
    import tlf_pkg::*;

    // digit-serial counter path geometry
    localparam int NDIG   = (TICK_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int PW     = NDIG * DIGIT_W;
    localparam int CNT_W  = $clog2(NDIG);
    localparam int HOLD_W = $clog2(HOLD_LIMIT + 1);

    localparam logic [CNT_W-1:0]  DIG_LAST = CNT_W'(NDIG - 1);
    localparam logic [HOLD_W-1:0] HOLD_MAX = HOLD_W'(HOLD_LIMIT);

    // control
    tlf_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // latched tick
    logic       op_reg;
    temp_t      temp_reg;
    logic       die_reg;
    core_mask_t online_reg;
    core_idx_t  cur_reg;

    // counter shift lines and deltas
    logic [PW-1:0]        idle_sr_reg, total_sr_reg;
    logic [PW-1:0]        di_sr_reg, dt_sr_reg;
    logic                 bi_reg, bt_reg;
    logic [DIGIT_W:0]     di_digit, dt_digit;
    logic [TICK_WIDTH-1:0] di, dt;
    logic                 upd_ok;

    // persistent state
    logic [PW-1:0]     prev_idle_reg, prev_idle_next;
    logic [PW-1:0]     prev_total_reg, prev_total_next;
    usage_t            usage_reg, usage_next;
    logic              lvl2_reg, lvl2_next;
    logic              warn_reg, warn_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    freq_t             last_cap_reg, last_cap_next;
    core_mask_t        stopped_reg, stopped_next;
    low_cnt_t          low_cnt_reg, low_cnt_next;
    logic              die_latch_reg, die_latch_next;
    logic              charge_reg, charge_next;

    // frequency registers
    freq_t full_reg, l0_reg, l1_reg, floor_reg;

    // output register
    logic       out_valid_reg, out_valid_next;
    freq_t      out_cap_reg;
    core_mask_t out_stop_reg, out_start_reg;
    logic       out_charge_reg;
    usage_t     out_usage_reg;
    logic       out_free;
    logic       fin_fire;
    logic       tick_fire;

    // divider
    logic   div_start;
    logic   div_done;
    usage_t div_quot;

    // tick decision results
    freq_t      d_cap;
    core_mask_t d_stop, d_start, d_stopped, d_pick;
    logic       d_lvl2, d_warn, d_charge, d_paused, d_fault, d_held;
    logic [HOLD_W-1:0] d_hold;
    freq_t      d_last_cap;
    low_cnt_t   d_low_cnt;
    temp_t      d_thr;
    logic       u_over, u_under, u_low;

    assign tick.ready = (state_reg == S_IDLE);
    assign tick_fire  = tick.valid && tick.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign fin_fire   = (state_reg == S_FIN) && out_free;

    // one digit of each delta per cycle, borrow carried between digits
    assign di_digit = {1'b0, idle_sr_reg[DIGIT_W-1:0]}
                    - {1'b0, prev_idle_reg[DIGIT_W-1:0]}
                    - {{DIGIT_W{1'b0}}, bi_reg};
    assign dt_digit = {1'b0, total_sr_reg[DIGIT_W-1:0]}
                    - {1'b0, prev_total_reg[DIGIT_W-1:0]}
                    - {{DIGIT_W{1'b0}}, bt_reg};

    // pad digits above the tick width are dropped here
    assign di     = di_sr_reg[TICK_WIDTH-1:0];
    assign dt     = dt_sr_reg[TICK_WIDTH-1:0];
    assign upd_ok = (dt != '0) && (di <= dt);

    tlf_sdiv #(
        .W (TICK_WIDTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (di),
        .den   (dt),
        .quot  (div_quot),
        .done  (div_done)
    );

    // core to stop: first of cores 1 and 2 that is online and not the governor
    always_comb
    begin
        d_pick = '0;
        if ((cur_reg != CORE_A) && online_reg[CORE_A])
        begin
            d_pick[CORE_A] = 1'b1;
        end
        else if ((cur_reg != CORE_B) && online_reg[CORE_B])
        begin
            d_pick[CORE_B] = 1'b1;
        end
    end

    // cap, hold, core and charge decisions from the settled usage
    always_comb
    begin
        u_over     = (usage_reg >= USAGE_ABOVE_OVER);
        u_under    = (usage_reg >= USAGE_ABOVE_UNDER);
        u_low      = (usage_reg < USAGE_BELOW_OVER);
        d_thr      = lvl2_reg ? T_LEVEL2_LOW : T_LEVEL2;
        d_fault    = die_reg || die_latch_reg;
        d_cap      = floor_reg;
        d_stop     = '0;
        d_start    = '0;
        d_stopped  = stopped_reg;
        d_lvl2     = lvl2_reg;
        d_warn     = warn_reg;
        d_hold     = hold_reg;
        d_last_cap = last_cap_reg;
        d_low_cnt  = low_cnt_reg;
        d_held     = 1'b0;
        if (op_reg)
        begin
            // boost: bring everything back, cap by temperature only
            d_start   = stopped_reg;
            d_stopped = '0;
            if (d_fault)
                d_cap = floor_reg;
            else if (temp_reg < T_BOOST_MAX)
                d_cap = full_reg;
            else if (temp_reg < T_BOOST_LIMIT)
                d_cap = l0_reg;
            else
                d_cap = l1_reg;
        end
        else
        begin
            if (temp_reg < T_BAND0)
                d_cap = u_over ? full_reg : (u_under ? l0_reg : floor_reg);
            else if (temp_reg < T_BAND1)
                d_cap = u_over ? l0_reg : (u_under ? l1_reg : floor_reg);
            else if (temp_reg < d_thr)
                d_cap = u_over ? l1_reg : floor_reg;
            else
            begin
                d_cap  = floor_reg;
                d_lvl2 = 1'b1;
                d_warn = 1'b1;
            end

            if (d_fault)
            begin
                d_last_cap = floor_reg;
                d_hold     = '0;
                d_cap      = floor_reg;
            end
            else
            begin
                if (u_low)
                begin
                    if (low_cnt_reg != LOW_CNT_MAX)
                        d_low_cnt = low_cnt_reg + low_cnt_t'(1);
                end
                else
                begin
                    d_low_cnt = '0;
                end

                if ((stopped_reg != '0) && (d_low_cnt > LOW_CNT_RESTART)
                    && (temp_reg < T_DOWN2))
                begin
                    d_start   = stopped_reg;
                    d_stopped = '0;
                end
                else if (temp_reg < T_BAND1)
                begin
                    d_start   = stopped_reg;
                    d_stopped = '0;
                end
                else if (temp_reg >= T_DOWN2)
                begin
                    d_stop    = d_pick;
                    d_stopped = stopped_reg | d_pick;
                end
                else if ((temp_reg >= T_DOWN1) && (stopped_reg == '0) && u_over)
                begin
                    d_stop    = d_pick;
                    d_stopped = stopped_reg | d_pick;
                end

                // warning hold: keep the old cap while it would rise
                if (d_warn)
                begin
                    if (last_cap_reg < d_cap)
                    begin
                        if (hold_reg < HOLD_MAX)
                        begin
                            d_hold = hold_reg + HOLD_W'(1);
                            d_cap  = last_cap_reg;
                            d_held = 1'b1;
                        end
                        else
                        begin
                            d_warn = 1'b0;
                            d_lvl2 = 1'b0;
                        end
                    end
                    if (!d_held)
                    begin
                        d_hold     = '0;
                        d_last_cap = d_cap;
                    end
                end
            end
        end

        // charge pause with hysteresis
        if (u_low && (temp_reg < T_DOWN2))
        begin
            d_charge = 1'b0;
            d_paused = 1'b0;
        end
        else if (temp_reg > T_CHARGE_STOP)
        begin
            d_charge = 1'b1;
            d_paused = 1'b1;
        end
        else if (!charge_reg)
        begin
            d_charge = 1'b0;
            d_paused = 1'b0;
        end
        else if (temp_reg < T_CHARGE_GO)
        begin
            d_charge = 1'b0;
            d_paused = 1'b0;
        end
        else
        begin
            d_charge = 1'b1;
            d_paused = 1'b1;
        end
    end

    // next state and state updates
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        prev_idle_next  = prev_idle_reg;
        prev_total_next = prev_total_reg;
        usage_next      = usage_reg;
        lvl2_next       = lvl2_reg;
        warn_next       = warn_reg;
        hold_next       = hold_reg;
        last_cap_next   = last_cap_reg;
        stopped_next    = stopped_reg;
        low_cnt_next    = low_cnt_reg;
        die_latch_next  = die_latch_reg;
        charge_next     = charge_reg;
        div_start       = 1'b0;
        out_valid_next  = out_valid_reg && !result.ready;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (tick.valid)
                    state_next = tick.op ? S_FIN : S_DELTA;
            end
            S_DELTA:
            begin
                // previous counters rotate back to place after the last digit
                prev_idle_next  = {prev_idle_reg[DIGIT_W-1:0], prev_idle_reg[PW-1:DIGIT_W]};
                prev_total_next = {prev_total_reg[DIGIT_W-1:0],
                                   prev_total_reg[PW-1:DIGIT_W]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIG_LAST)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (upd_ok)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    usage_next      = FULL_SCALE - div_quot;
                    prev_idle_next  = idle_sr_reg;
                    prev_total_next = total_sr_reg;
                    if (die_reg && (temp_reg < T_LEVEL2))
                        die_latch_next = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    lvl2_next      = d_lvl2;
                    warn_next      = d_warn;
                    hold_next      = d_hold;
                    last_cap_next  = d_last_cap;
                    stopped_next   = d_stopped;
                    low_cnt_next   = d_low_cnt;
                    charge_next    = d_paused;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            prev_idle_reg  <= '0;
            prev_total_reg <= '0;
            usage_reg      <= '0;
            lvl2_reg       <= 1'b0;
            warn_reg       <= 1'b0;
            hold_reg       <= '0;
            last_cap_reg   <= RESET_FLOOR;
            stopped_reg    <= '0;
            low_cnt_reg    <= '0;
            die_latch_reg  <= 1'b0;
            charge_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            full_reg       <= RESET_FULL;
            l0_reg         <= RESET_LEVEL0;
            l1_reg         <= RESET_LEVEL1;
            floor_reg      <= RESET_FLOOR;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            prev_idle_reg  <= prev_idle_next;
            prev_total_reg <= prev_total_next;
            usage_reg      <= usage_next;
            lvl2_reg       <= lvl2_next;
            warn_reg       <= warn_next;
            hold_reg       <= hold_next;
            last_cap_reg   <= last_cap_next;
            stopped_reg    <= stopped_next;
            low_cnt_reg    <= low_cnt_next;
            die_latch_reg  <= die_latch_next;
            charge_reg     <= charge_next;
            out_valid_reg  <= out_valid_next;
            if (wr_en)
            begin
                case (wr_index)
                    REG_FULL:   full_reg  <= wr_data;
                    REG_LEVEL0: l0_reg    <= wr_data;
                    REG_LEVEL1: l1_reg    <= wr_data;
                    REG_FLOOR:  floor_reg <= wr_data;
                    default:    ;
                endcase
            end
        end
    end

    // payload: latched tick, counter shift lines, result beat
    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            op_reg       <= tick.op;
            temp_reg     <= tick.temp_c;
            die_reg      <= tick.die_error;
            online_reg   <= tick.online_mask;
            cur_reg      <= tick.current_core;
            idle_sr_reg  <= PW'(TICK_WIDTH'(tick.idle_ticks));
            total_sr_reg <= PW'(TICK_WIDTH'(tick.total_ticks));
            bi_reg       <= 1'b0;
            bt_reg       <= 1'b0;
        end
        else if (state_reg == S_DELTA)
        begin
            idle_sr_reg  <= {idle_sr_reg[DIGIT_W-1:0], idle_sr_reg[PW-1:DIGIT_W]};
            total_sr_reg <= {total_sr_reg[DIGIT_W-1:0], total_sr_reg[PW-1:DIGIT_W]};
            di_sr_reg    <= {di_digit[DIGIT_W-1:0], di_sr_reg[PW-1:DIGIT_W]};
            dt_sr_reg    <= {dt_digit[DIGIT_W-1:0], dt_sr_reg[PW-1:DIGIT_W]};
            bi_reg       <= di_digit[DIGIT_W];
            bt_reg       <= dt_digit[DIGIT_W];
        end
        if (fin_fire)
        begin
            out_cap_reg    <= d_cap;
            out_stop_reg   <= d_stop;
            out_start_reg  <= d_start;
            out_charge_reg <= d_charge;
            out_usage_reg  <= usage_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.max_freq_khz = out_cap_reg;
    assign result.stop_mask    = out_stop_reg;
    assign result.start_mask   = out_start_reg;
    assign result.charge_stop  = out_charge_reg;
    assign result.usage_x100   = out_usage_reg;

    // only cores 1 and 2 are ever taken offline
    a_stop_cores: assert property (@(posedge clk) disable iff (!rst_n)
        !stopped_reg[0] && !stopped_reg[3])
        else $error("limiter: core 0 or 3 marked stopped");

    a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg <= HOLD_MAX)
        else $error("limiter: hold count beyond limit");

    a_die_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        die_latch_reg |=> die_latch_reg)
        else $error("limiter: die latch cleared");

    a_usage_range: assert property (@(posedge clk) disable iff (!rst_n)
        usage_reg <= FULL_SCALE)
        else $error("limiter: usage above full scale");

    // lowered threshold and warning are set and cleared together
    a_warn_pair: assert property (@(posedge clk) disable iff (!rst_n)
        lvl2_reg == warn_reg)
        else $error("limiter: level-2 flag and warning disagree");

endmodule

`default_nettype wire

// ----- dv/thermal_load_freq_limiter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_load_freq_limiter_tb: self-checking bench for the frequency limiter
// drives tick beats with random pacing on both channels, predicts every
// result beat with a behavioral model of the limiter and compares it field
// by field, across several frequency register settings
// ----------------------------------------------------------------------------

module thermal_load_freq_limiter_tb;
    import tlf_pkg::*;

    // op codes of the tick channel
    localparam logic OP_NORMAL = 1'b0;
    localparam logic OP_BOOST  = 1'b1;

    localparam int HOLD_TICKS      = 60;       // warning hold length given to the dut
    localparam int FREQ_TOP        = 4000000;  // highest legal cap value
    localparam int HOLD_OFF_CYCLES = 300;      // long receiver stall
    localparam int DRAIN_CYCLES    = 40;       // wait after the drain for any stray beat
    localparam int CYCLE_LIMIT     = 600000;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        logic       op;
        temp_t      temp_c;
        tick_cnt_t  idle_ticks;
        tick_cnt_t  total_ticks;
        logic       die_error;
        core_mask_t online_mask;
        core_idx_t  current_core;
    } tick_beat_t;

    typedef struct {
        freq_t      max_freq_khz;
        core_mask_t stop_mask;
        core_mask_t start_mask;
        logic       charge_stop;
        usage_t     usage_x100;
    } limiter_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic wr_en;
    reg_index_t wr_index;
    freq_t wr_data;

    tlf_in_if  tick_if ();
    tlf_out_if res_if ();

    thermal_load_freq_limiter #(
        .TICK_WIDTH (32),
        .HOLD_LIMIT (HOLD_TICKS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick_if),
        .result   (res_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // limiter model state, mirrors the block's registers
    // ------------------------------------------------------------------
    freq_t      full_khz, level0_khz, level1_khz, floor_khz;
    tick_cnt_t  seen_idle, seen_total;      // counters of the last usage update
    usage_t     usage_now;
    logic       level2_low;                 // level-2 band starts at 57 instead of 62
    logic       warn_on;
    logic       die_latched;
    logic       charge_held;
    int         hold_ticks;
    freq_t      last_cap;
    core_mask_t parked_cores;
    int         low_load_ticks;

    limiter_result_t predicted_limits[$];   // one entry per accepted tick, oldest first

    bit idling_on = 1'b1;                   // random gaps and stalls allowed
    int hold_off_asked = 0;                 // bumped to request a long receiver stall
    int mismatch_count = 0;

    // lowest of cores 1 and 2 that is online and not the governor's core
    function automatic core_mask_t park_candidate(core_mask_t online, core_idx_t cur);
        for (int c = CORE_A; c <= CORE_B; c++)
        begin
            if (c != int'(cur) && online[c])
                return core_mask_t'(1 << c);
        end
        return '0;
    endfunction

    // advance the model by one accepted tick and return the result it implies
    function automatic limiter_result_t predict_limit(tick_beat_t b);
        int t;
        int pct;
        int thr;
        freq_t cap;
        core_mask_t stop_m;
        core_mask_t start_m;
        tick_cnt_t di;
        tick_cnt_t dt;
        logic held;
        limiter_result_t r;
        t = int'(b.temp_c);
        stop_m = '0;
        start_m = '0;
        if (b.op == OP_BOOST)
        begin
            // boost restarts everything parked, cap by temperature only
            start_m = parked_cores;
            parked_cores = '0;
            if (b.die_error || die_latched)
                cap = floor_khz;
            else if (t < T_BOOST_MAX)
                cap = full_khz;
            else if (t < T_BOOST_LIMIT)
                cap = level0_khz;
            else
                cap = level1_khz;
        end
        else
        begin
            di = b.idle_ticks - seen_idle;
            dt = b.total_ticks - seen_total;
            // zero total delta or idle above total: keep everything
            if (dt != 0 && di <= dt)
            begin
                usage_now = FULL_SCALE - usage_t'((64'(di) * 64'd10000) / 64'(dt));
                seen_idle = b.idle_ticks;
                seen_total = b.total_ticks;
                if (b.die_error && t < T_LEVEL2)
                    die_latched = 1'b1;
            end
            pct = usage_now / 100;
            thr = level2_low ? int'(T_LEVEL2_LOW) : int'(T_LEVEL2);
            if (t < T_BAND0)
                cap = (pct > U_OVER) ? full_khz : ((pct > U_UNDER) ? level0_khz : floor_khz);
            else if (t < T_BAND1)
                cap = (pct > U_OVER) ? level0_khz : ((pct > U_UNDER) ? level1_khz : floor_khz);
            else if (t < thr)
                cap = (pct > U_OVER) ? level1_khz : floor_khz;
            else
            begin
                cap = floor_khz;
                level2_low = 1'b1;
                warn_on = 1'b1;
            end

            if (b.die_error || die_latched)
            begin
                last_cap = floor_khz;
                hold_ticks = 0;
                cap = floor_khz;
            end
            else
            begin
                if (pct < U_OVER)
                begin
                    if (low_load_ticks < 255)
                        low_load_ticks++;
                end
                else
                    low_load_ticks = 0;

                if (parked_cores != 0 && low_load_ticks > 5 && t < T_DOWN2)
                begin
                    start_m = parked_cores;
                    parked_cores = '0;
                end
                else if (t < T_BAND1)
                begin
                    start_m = parked_cores;
                    parked_cores = '0;
                end
                else if (t >= T_DOWN2)
                begin
                    stop_m = park_candidate(b.online_mask, b.current_core);
                    parked_cores |= stop_m;
                end
                else if (t >= T_DOWN1 && parked_cores == 0 && pct > U_OVER)
                begin
                    stop_m = park_candidate(b.online_mask, b.current_core);
                    parked_cores |= stop_m;
                end

                // after a warning the cap may only rise once the hold runs out
                if (warn_on)
                begin
                    held = 1'b0;
                    if (last_cap < cap)
                    begin
                        if (hold_ticks < HOLD_TICKS)
                        begin
                            hold_ticks++;
                            cap = last_cap;
                            held = 1'b1;
                        end
                        else
                        begin
                            warn_on = 1'b0;
                            level2_low = 1'b0;
                        end
                    end
                    if (!held)
                    begin
                        hold_ticks = 0;
                        last_cap = cap;
                    end
                end
            end
        end

        // charge pause with hysteresis between 56 and 57
        pct = usage_now / 100;
        if (pct < U_OVER && t < T_DOWN2)
        begin
            charge_held = 1'b0;
            r.charge_stop = 1'b0;
        end
        else if (t > T_CHARGE_STOP)
        begin
            charge_held = 1'b1;
            r.charge_stop = 1'b1;
        end
        else if (!charge_held)
            r.charge_stop = 1'b0;
        else if (t < T_CHARGE_GO)
        begin
            charge_held = 1'b0;
            r.charge_stop = 1'b0;
        end
        else
            r.charge_stop = 1'b1;

        r.max_freq_khz = cap;
        r.stop_mask = stop_m;
        r.start_mask = start_m;
        r.usage_x100 = usage_now;
        return r;
    endfunction

    // normal tick whose counters move by the given deltas from the last update
    function automatic tick_beat_t normal_tick(int t, longint unsigned di, longint unsigned dt);
        tick_beat_t b;
        b.op = OP_NORMAL;
        b.temp_c = temp_t'(t);
        b.idle_ticks = seen_idle + tick_cnt_t'(di);
        b.total_ticks = seen_total + tick_cnt_t'(dt);
        b.die_error = 1'b0;
        b.online_mask = 4'hF;
        b.current_core = '0;
        return b;
    endfunction

    // ------------------------------------------------------------------
    // tick channel driver: optional gap, then hold the beat until taken
    // ------------------------------------------------------------------
    task automatic send_tick(tick_beat_t b);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 7);
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_if.valid        <= 1'b1;
        tick_if.op           <= b.op;
        tick_if.temp_c       <= b.temp_c;
        tick_if.idle_ticks   <= b.idle_ticks;
        tick_if.total_ticks  <= b.total_ticks;
        tick_if.die_error    <= b.die_error;
        tick_if.online_mask  <= b.online_mask;
        tick_if.current_core <= b.current_core;
        @(posedge clk);
        while (tick_if.ready !== 1'b1)
            @(posedge clk);
        // beat taken at this edge, model moves in step with the block
        predicted_limits.push_back(predict_limit(b));
    endtask

    // write all four caps once the block has drained
    task automatic load_freq_regs(freq_t full_v, freq_t l0_v, freq_t l1_v, freq_t floor_v);
        tick_if.valid <= 1'b0;
        @(posedge clk);
        while (predicted_limits.size() != 0)
            @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= REG_FULL;
        wr_data  <= full_v;
        @(posedge clk);
        wr_index <= REG_LEVEL0;
        wr_data  <= l0_v;
        @(posedge clk);
        wr_index <= REG_LEVEL1;
        wr_data  <= l1_v;
        @(posedge clk);
        wr_index <= REG_FLOOR;
        wr_data  <= floor_v;
        @(posedge clk);
        wr_en    <= 1'b0;
        // last_cap is left alone, only reset reloads it
        full_khz   = full_v;
        level0_khz = l0_v;
        level1_khz = l1_v;
        floor_khz  = floor_v;
    endtask

    // temperature episodes with a steady load, mixed with boost, noise,
    // stalled counters and counter corrections
    task automatic run_random_ticks(int count, bit allow_idle);
        int done_n;
        int span;
        int base_t;
        int load_pct;
        int lp;
        int t;
        int kind;
        longint unsigned dt;
        longint unsigned di;
        tick_beat_t b;
        done_n = 0;
        while (done_n < count)
        begin
            // mostly short episodes, some long enough to run out the warning hold
            span = ($urandom_range(0, 5) == 0) ? int'($urandom_range(40, 90))
                                               : int'($urandom_range(1, 12));
            base_t = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 190)) - 40
                                                 : int'($urandom_range(38, 74));
            load_pct = $urandom_range(0, 100);
            idling_on = allow_idle && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < span && done_n < count; k++)
            begin
                t = base_t + int'($urandom_range(0, 4)) - 2;
                if (t < -40)
                    t = -40;
                if (t > 150)
                    t = 150;
                lp = load_pct + int'($urandom_range(0, 6)) - 3;
                if (lp < 0)
                    lp = 0;
                if (lp > 100)
                    lp = 100;
                dt = ($urandom_range(0, 9) == 0) ? longint'($urandom)
                                                 : longint'($urandom_range(1, 4000));
                di = dt * (100 - lp) / 100;
                b = normal_tick(t, di, dt);
                b.online_mask = core_mask_t'($urandom_range(0, 15));
                b.current_core = ($urandom_range(0, 2) == 0)
                                 ? core_idx_t'($urandom_range(0, 3)) : core_idx_t'(0);
                kind = $urandom_range(0, 99);
                if (kind < 12)
                begin
                    b.op = OP_BOOST;
                    b.die_error = ($urandom_range(0, 9) == 0);
                end
                else if (kind < 16)
                begin
                    // arbitrary counters, every bit moves
                    b.idle_ticks = $urandom;
                    b.total_ticks = $urandom;
                end
                else if (kind < 19)
                begin
                    // total counter stuck: no update, die report cannot latch
                    b.idle_ticks = seen_idle + $urandom;
                    b.total_ticks = seen_total;
                    b.die_error = ($urandom_range(0, 1) == 1);
                end
                else if (kind < 22)
                begin
                    // idle ran ahead of total: correction, no update
                    dt = longint'($urandom_range(0, 1000));
                    b.total_ticks = seen_total + tick_cnt_t'(dt);
                    b.idle_ticks = seen_idle + tick_cnt_t'(dt + $urandom_range(1, 1000));
                    b.die_error = ($urandom_range(0, 1) == 1);
                end
                else
                    // die report only when hot, so the latch stays clear
                    b.die_error = (t >= T_LEVEL2) && ($urandom_range(0, 19) == 0);
                send_tick(b);
                done_n++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        int band_t[8];
        int boost_t[4];
        tick_beat_t b;
        band_t = '{44, 45, 51, 52, 56, 57, 61, 62};
        boost_t = '{63, 64, 67, 68};
        send_tick(normal_tick(25, 0, 0));          // counters unchanged, usage stays
        send_tick(normal_tick(25, 50, 100));       // half load
        send_tick(normal_tick(25, 200, 100));      // idle delta above total delta
        send_tick(normal_tick(-40, 0, 1000));      // coldest, fully busy
        send_tick(normal_tick(150, 1000, 1000));   // hottest, fully idle, warning
        // band edges at high and middle load
        for (int i = 0; i < 8; i++)
            send_tick(normal_tick(band_t[i], (i % 2) ? 45 : 10, 100));
        b = normal_tick(62, 10, 100);
        b.online_mask = 4'b0000;                   // no core can be parked
        send_tick(b);
        b = normal_tick(67, 10, 100);
        b.current_core = CORE_A;                   // governor on core 1, core 2 goes
        send_tick(b);
        b = normal_tick(68, 10, 100);
        b.online_mask = 4'b0010;
        send_tick(b);
        // boost bands, last one with a die report
        for (int i = 0; i < 4; i++)
        begin
            b = normal_tick(boost_t[i], 0, 0);
            b.op = OP_BOOST;
            b.die_error = (i == 3);
            send_tick(b);
        end
        b = normal_tick(70, 20, 100);
        b.die_error = 1'b1;                        // hot die report, no latch
        send_tick(b);
        send_tick(normal_tick(56, 5, 100));        // charge pause held
        send_tick(normal_tick(55, 5, 100));        // charge pause released
        b = normal_tick(30, 0, 0);
        b.idle_ticks = '1;
        b.total_ticks = '1;                        // counters at the top
        send_tick(b);
        b.idle_ticks = 32'd5;
        b.total_ticks = 32'd10;                    // both counters wrapped
        send_tick(b);
    endtask

    // heat up, then cool at high load: cap held low for the whole hold
    task automatic test_warning_hold();
        repeat (3)
            send_tick(normal_tick(65, $urandom_range(0, 10), 100));
        repeat (66)
            send_tick(normal_tick(30, $urandom_range(0, 10), 100));
    endtask

    task automatic test_register_sweep();
        freq_t r0, r1, r2, r3;
        load_freq_regs('0, '0, '0, '0);
        run_random_ticks(270, 1'b1);
        load_freq_regs(freq_t'(FREQ_TOP), freq_t'(FREQ_TOP), freq_t'(FREQ_TOP),
                       freq_t'(FREQ_TOP));
        run_random_ticks(270, 1'b1);
        // floor above full: hold compares run the other way
        load_freq_regs('0, freq_t'(1000), freq_t'(2000000), freq_t'(FREQ_TOP));
        run_random_ticks(270, 1'b1);
        for (int p = 0; p < 3; p++)
        begin
            r0 = freq_t'($urandom_range(0, FREQ_TOP));
            r1 = freq_t'($urandom_range(0, FREQ_TOP));
            r2 = freq_t'($urandom_range(0, FREQ_TOP));
            r3 = freq_t'($urandom_range(0, FREQ_TOP));
            load_freq_regs(r0, r1, r2, r3);
            run_random_ticks(270, p != 1);
        end
    endtask

    // receiver stops for a long while, the block fills and stalls its input
    task automatic test_output_backpressure();
        hold_off_asked++;
        run_random_ticks(24, 1'b0);
    endtask

    task automatic test_quiet_tail();
        load_freq_regs(RESET_FULL, RESET_LEVEL0, RESET_LEVEL1, RESET_FLOOR);
        run_random_ticks(180, 1'b0);
    endtask

    // die report on a cool updated tick latches until reset, so it runs last
    task automatic test_die_latch();
        tick_beat_t b;
        b = normal_tick(40, 30, 100);
        b.die_error = 1'b1;
        send_tick(b);
        run_random_ticks(30, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // result channel: ready pacing with random stalls and requested holds
    // ------------------------------------------------------------------
    initial
    begin : sink_pacing
        int stall_left;
        int hold_left;
        int holds_served;
        stall_left = 0;
        hold_left = 0;
        holds_served = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_off_asked)
            begin
                holds_served++;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (!rst_n)
                res_if.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    task automatic report_mismatch(string field, longint unsigned want_v, longint unsigned got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch %s: expected %0d, got %0d", $realtime, field, want_v, got_v);
    endtask

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        limiter_result_t want;
        if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            if (predicted_limits.size() == 0)
                report_mismatch("beat with no tick pending", 0, res_if.max_freq_khz);
            else
            begin
                want = predicted_limits.pop_front();
                if (res_if.max_freq_khz !== want.max_freq_khz)
                    report_mismatch("max_freq_khz", want.max_freq_khz, res_if.max_freq_khz);
                if (res_if.stop_mask !== want.stop_mask)
                    report_mismatch("stop_mask", want.stop_mask, res_if.stop_mask);
                if (res_if.start_mask !== want.start_mask)
                    report_mismatch("start_mask", want.start_mask, res_if.start_mask);
                if (res_if.charge_stop !== want.charge_stop)
                    report_mismatch("charge_stop", want.charge_stop, res_if.charge_stop);
                if (res_if.usage_x100 !== want.usage_x100)
                    report_mismatch("usage_x100", want.usage_x100, res_if.usage_x100);
            end
        end
    end

    // run length guard
    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("thermal_load_freq_limiter_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // model starts from the reset state
        full_khz = RESET_FULL;
        level0_khz = RESET_LEVEL0;
        level1_khz = RESET_LEVEL1;
        floor_khz = RESET_FLOOR;
        seen_idle = '0;
        seen_total = '0;
        usage_now = '0;
        level2_low = 1'b0;
        warn_on = 1'b0;
        die_latched = 1'b0;
        charge_held = 1'b0;
        hold_ticks = 0;
        last_cap = RESET_FLOOR;
        parked_cores = '0;
        low_load_ticks = 0;

        // every input known from time zero
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_FULL;
        wr_data = '0;
        tick_if.valid = 1'b0;
        tick_if.op = OP_NORMAL;
        tick_if.temp_c = '0;
        tick_if.idle_ticks = '0;
        tick_if.total_ticks = '0;
        tick_if.die_error = 1'b0;
        tick_if.online_mask = '0;
        tick_if.current_core = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_warning_hold();
        test_register_sweep();
        test_output_backpressure();
        test_quiet_tail();
        test_die_latch();

        // drain, then a further wait for any stray beat
        tick_if.valid <= 1'b0;
        while (predicted_limits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("thermal_load_freq_limiter_tb OK");
        else
            $display("thermal_load_freq_limiter_tb NOT OK");
        $finish;
    end

endmodule
